[rtl/core/ihhk_pkg.sv]
package ihhk_pkg;

    // Field widths of the item and result channels.
    localparam int KEY_BITS  = 8;
    localparam int TAG_BITS  = 16;
    localparam int ACT_BITS  = 2;
    localparam int STAT_BITS = 3;
    localparam int CFG_BITS  = 7;

    // Every key value has its own presence bit and its own tag slot.
    localparam int KEY_SPAN = 1 << KEY_BITS;

    // Capacity register value after reset.
    localparam logic [CFG_BITS-1:0] CFG_RESET = 7'd64;

    // Action codes.
    localparam logic [ACT_BITS-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_BITS-1:0] ACT_HALVE  = 2'd1;
    localparam logic [ACT_BITS-1:0] ACT_REMOVE = 2'd2;

    // Status codes.
    localparam logic [STAT_BITS-1:0] ST_OK           = 3'd0;
    localparam logic [STAT_BITS-1:0] ST_FULL         = 3'd1;
    localparam logic [STAT_BITS-1:0] ST_EMPTY        = 3'd2;
    localparam logic [STAT_BITS-1:0] ST_KEY_PRESENT  = 3'd3;
    localparam logic [STAT_BITS-1:0] ST_KEY_ABSENT   = 3'd4;
    localparam logic [STAT_BITS-1:0] ST_HALF_PRESENT = 3'd5;

    // Operation broadcast to every cell of the sorted chain.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_HALVE,
        CELL_SHIFT_OUT
    } t_cell_op;

    // key_a is the key that enters the chain, key_b the key that leaves it
    // on a halve.
    typedef struct packed {
        t_cell_op            op;
        logic [KEY_BITS-1:0] key_a;
        logic [KEY_BITS-1:0] key_b;
    } t_cell_cmd;

endpackage

[rtl/core/ihhk_cell.sv]
module ihhk_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ihhk_pkg::t_cell_cmd           i_cmd,
    input  logic [ihhk_pkg::KEY_BITS-1:0] i_prev_key,
    input  logic                          i_prev_valid,
    input  logic                          i_prev_move,
    input  logic [ihhk_pkg::KEY_BITS-1:0] i_next_key,
    input  logic                          i_next_valid,
    output logic [ihhk_pkg::KEY_BITS-1:0] o_key,
    output logic                          o_valid,
    output logic                          o_move
);
    import ihhk_pkg::*;

    logic [KEY_BITS-1:0] r_key;
    logic                r_valid;
    logic [KEY_BITS-1:0] n_key;
    logic                n_valid;
    logic                above_a;
    logic                in_halve_span;

    // The chain stays sorted ascending with empty cells at the far end, so
    // a cell at or beyond the entry point of key_a is empty or holds more.
    assign above_a       = r_key > i_cmd.key_a;
    assign o_move        = !r_valid || above_a;
    assign in_halve_span = r_valid && above_a && (r_key <= i_cmd.key_b);

    // Next content: keep, take from the lower neighbor, take the new key,
    // or take from the upper neighbor when the smallest entry leaves.
    always_comb begin
        n_key   = r_key;
        n_valid = r_valid;
        case (i_cmd.op)
            CELL_INSERT: begin
                if (o_move) begin
                    if (i_prev_move) begin
                        n_key   = i_prev_key;
                        n_valid = i_prev_valid;
                    end else begin
                        n_key   = i_cmd.key_a;
                        n_valid = 1'b1;
                    end
                end
            end
            CELL_HALVE: begin
                // Entries between the halved key and the old key move up one
                // place; the old key is overwritten along the way.
                if (in_halve_span) begin
                    n_key = i_prev_move ? i_prev_key : i_cmd.key_a;
                end
            end
            CELL_SHIFT_OUT: begin
                n_key   = i_next_key;
                n_valid = i_next_valid;
            end
            default: begin
                n_key   = r_key;
                n_valid = r_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key   = r_key;
    assign o_valid = r_valid;

endmodule

[rtl/core/indexed_min_heap_halve_key.sv]
// Channel     Direction  Handshake           Contents
// item        in         i_valid / o_stall   i_action, i_key, i_payload
// result      out        o_valid / i_stall   o_status ... o_is_full
// capacity    in         i_cfg_we            i_cfg_data
//
// An item goes through accept, execute on the cell chain, registered tag
// memory read of the new smallest key, and result load; that read can only
// start once the chain has moved. No new item is accepted until the result
// is loaded, but one is accepted while the earlier loaded result still waits
// behind i_stall. Reset clears the presence bits and the cell valid bits;
// no clearing pass follows.
module indexed_min_heap_halve_key #(
    parameter int CAPACITY = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [ihhk_pkg::ACT_BITS-1:0]    i_action,
    input  logic [ihhk_pkg::KEY_BITS-1:0]    i_key,
    input  logic [ihhk_pkg::TAG_BITS-1:0]    i_payload,
    input  logic                             i_cfg_we,
    input  logic [ihhk_pkg::CFG_BITS-1:0]    i_cfg_data,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [ihhk_pkg::STAT_BITS-1:0]   o_status,
    output logic                             o_key_was_present,
    output logic [ihhk_pkg::KEY_BITS-1:0]    o_min_key,
    output logic [ihhk_pkg::TAG_BITS-1:0]    o_min_payload,
    output logic [$clog2(CAPACITY+1)-1:0]    o_entry_count,
    output logic                             o_is_empty,
    output logic                             o_is_full
);
    import ihhk_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = (CW > CFG_BITS) ? CW : CFG_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [CFG_BITS-1:0]  r_cfg;
    logic [ACT_BITS-1:0]  r_act;
    logic [KEY_BITS-1:0]  r_key;
    logic [TAG_BITS-1:0]  r_tag_in;
    logic [CW-1:0]        r_count;
    logic [KEY_SPAN-1:0]  r_pres;
    logic [STAT_BITS-1:0] r_status;
    logic                 r_present;
    logic                 r_ovalid;
    logic [STAT_BITS-1:0] r_o_status;
    logic                 r_o_present;
    logic [KEY_BITS-1:0]  r_o_min_key;
    logic [TAG_BITS-1:0]  r_o_min_tag;
    logic [CW-1:0]        r_o_count;
    logic                 r_o_empty;
    logic                 r_o_full;

    logic [TAG_BITS-1:0]  r_tag_mem [KEY_SPAN];
    logic [TAG_BITS-1:0]  r_tag_rd;

    logic [KEY_BITS-1:0]  w_key   [CAPACITY];
    logic                 w_valid [CAPACITY];
    logic                 w_move  [CAPACITY];

    logic [KEY_BITS-1:0]  half_key;
    logic                 present;
    logic                 half_present;
    logic [EW-1:0]        eff_cap;
    logic                 full;
    logic [STAT_BITS-1:0] status;
    logic                 apply;
    t_cell_cmd            cmd;
    logic                 tag_we;
    logic [KEY_BITS-1:0]  tag_wr_addr;
    logic [TAG_BITS-1:0]  tag_wr_data;
    logic                 tag_re;
    logic [KEY_BITS-1:0]  tag_rd_addr;
    logic                 accept;

    assign accept  = i_valid && (r_state == S_IDLE);
    assign o_stall = (r_state != S_IDLE);

    // Precondition checks against presence bits, count and capacity.
    assign half_key     = r_key >> 1;
    assign present      = r_pres[r_key];
    assign half_present = r_pres[half_key];
    assign eff_cap      = (EW'(r_cfg) > EW'(CAPACITY)) ? EW'(CAPACITY) : EW'(r_cfg);
    assign full         = EW'(r_count) >= eff_cap;

    always_comb begin
        status = ST_OK;
        case (r_act)
            ACT_INSERT: begin
                if (full) begin
                    status = ST_FULL;
                end else if (present) begin
                    status = ST_KEY_PRESENT;
                end
            end
            ACT_HALVE: begin
                if (!present) begin
                    status = ST_KEY_ABSENT;
                end else if (half_present) begin
                    status = ST_HALF_PRESENT;
                end
            end
            ACT_REMOVE: begin
                if (r_count == '0) begin
                    status = ST_EMPTY;
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    assign apply = (r_state == S_EXEC) && (status == ST_OK);

    // Command for the cell chain, issued only in the execute cycle.
    always_comb begin
        cmd.op    = CELL_HOLD;
        cmd.key_a = r_key;
        cmd.key_b = r_key;
        if (apply) begin
            case (r_act)
                ACT_INSERT: begin
                    cmd.op = CELL_INSERT;
                end
                ACT_HALVE: begin
                    cmd.op    = CELL_HALVE;
                    cmd.key_a = half_key;
                end
                ACT_REMOVE: begin
                    cmd.op = CELL_SHIFT_OUT;
                end
                default: begin
                    cmd.op = CELL_HOLD;
                end
            endcase
        end
    end

    // Sorted chain of cells; cell 0 holds the smallest key.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_BITS-1:0] prev_key;
        logic                prev_valid;
        logic                prev_move;
        logic [KEY_BITS-1:0] next_key;
        logic                next_valid;

        if (g == 0) begin : g_first
            assign prev_key   = '0;
            assign prev_valid = 1'b0;
            assign prev_move  = 1'b0;
        end else begin : g_inner
            assign prev_key   = w_key[g-1];
            assign prev_valid = w_valid[g-1];
            assign prev_move  = w_move[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign next_key   = '0;
            assign next_valid = 1'b0;
        end else begin : g_body
            assign next_key   = w_key[g+1];
            assign next_valid = w_valid[g+1];
        end

        ihhk_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cmd),
            .i_prev_key   (prev_key),
            .i_prev_valid (prev_valid),
            .i_prev_move  (prev_move),
            .i_next_key   (next_key),
            .i_next_valid (next_valid),
            .o_key        (w_key[g]),
            .o_valid      (w_valid[g]),
            .o_move       (w_move[g])
        );
    end

    // Tags are stored by key: a halve copies the tag of the old key, which
    // was read when the item was accepted.
    assign tag_we      = apply && ((r_act == ACT_INSERT) || (r_act == ACT_HALVE));
    assign tag_wr_addr = (r_act == ACT_INSERT) ? r_key : half_key;
    assign tag_wr_data = (r_act == ACT_INSERT) ? r_tag_in : r_tag_rd;
    assign tag_re      = accept || (r_state == S_READ);
    assign tag_rd_addr = (r_state == S_READ) ? w_key[0] : i_key;

    always_ff @(posedge i_clk) begin
        if (tag_we) begin
            r_tag_mem[tag_wr_addr] <= tag_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tag_re) begin
            r_tag_rd <= r_tag_mem[tag_rd_addr];
        end
    end

    // Sequencer, presence bits, count and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cfg    <= CFG_RESET;
            r_count  <= '0;
            r_pres   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            // The result register empties when taken, unless a new result
            // is loaded in the same cycle.
            if (r_ovalid && !i_stall && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_act    <= i_action;
                        r_key    <= i_key;
                        r_tag_in <= i_payload;
                        r_state  <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_status  <= status;
                    r_present <= present;
                    if (apply) begin
                        case (r_act)
                            ACT_INSERT: begin
                                r_pres[r_key] <= 1'b1;
                                r_count       <= r_count + CW'(1);
                            end
                            ACT_HALVE: begin
                                r_pres[r_key]    <= 1'b0;
                                r_pres[half_key] <= 1'b1;
                            end
                            ACT_REMOVE: begin
                                r_pres[w_key[0]] <= 1'b0;
                                r_count          <= r_count - CW'(1);
                            end
                            default: begin
                                r_count <= r_count;
                            end
                        endcase
                    end
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid    <= 1'b1;
                        r_o_status  <= r_status;
                        r_o_present <= r_present;
                        r_o_min_key <= w_valid[0] ? w_key[0] : '0;
                        r_o_min_tag <= w_valid[0] ? r_tag_rd : '0;
                        r_o_count   <= r_count;
                        r_o_empty   <= (r_count == '0);
                        r_o_full    <= full;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid           = r_ovalid;
    assign o_status          = r_o_status;
    assign o_key_was_present = r_o_present;
    assign o_min_key         = r_o_min_key;
    assign o_min_payload     = r_o_min_tag;
    assign o_entry_count     = r_o_count;
    assign o_is_empty        = r_o_empty;
    assign o_is_full         = r_o_full;

endmodule

[bench/indexed_min_heap_halve_key_test.sv]
`timescale 1ns / 1ps

module indexed_min_heap_halve_key_test;

    import ihhk_pkg::*;

    // Action code 3 is unused: the block leaves its state alone and reports ok.
    localparam logic [ACT_BITS-1:0] ACT_SPARE = 2'd3;
    localparam int CNT_BITS      = 7;
    localparam int HEAP_SLOTS    = 64;
    localparam int IDLE_LIMIT    = 3000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_ITEMS   = 103;

    // Everything the block reports for one item.
    typedef struct packed {
        logic [STAT_BITS-1:0] status;
        logic                 was_present;
        logic [KEY_BITS-1:0]  min_key;
        logic [TAG_BITS-1:0]  min_tag;
        logic [CNT_BITS-1:0]  count;
        logic                 empty;
        logic                 full;
    } t_heap_view;

    // Tracks which keys the heap holds and the view each item should produce.
    // Keys are distinct, so the smallest key and its tag do not depend on how
    // the entries are arranged in the chain.
    class t_heap_scoreboard;
        bit                  held[KEY_SPAN];
        logic [TAG_BITS-1:0] tag_of[KEY_SPAN];
        int unsigned         entries;
        logic [CFG_BITS-1:0] capacity;
        t_heap_view          view_q[$];
        int unsigned         mismatches;

        function new();
            foreach (held[k]) held[k] = 1'b0;
            entries    = 0;
            capacity   = CFG_RESET;
            mismatches = 0;
        endfunction

        function void set_capacity(logic [CFG_BITS-1:0] value);
            capacity = value;
        endfunction

        // Capacities above the heap size are clamped to it.
        function int unsigned room();
            return (capacity > HEAP_SLOTS) ? HEAP_SLOTS : capacity;
        endfunction

        function int unsigned pending();
            return view_q.size();
        endfunction

        function int unsigned smallest_key();
            for (int k = 0; k < KEY_SPAN; k++) begin
                if (held[k]) return k;
            end
            return 0;
        endfunction

        // Returns some key that is held, or the fallback when the heap is empty.
        function logic [KEY_BITS-1:0] pick_held_key(logic [KEY_BITS-1:0] fallback);
            int unsigned start;
            int unsigned k;
            start = $urandom_range(0, KEY_SPAN - 1);
            for (int i = 0; i < KEY_SPAN; i++) begin
                k = (start + i) % KEY_SPAN;
                if (held[k]) return KEY_BITS'(k);
            end
            return fallback;
        endfunction

        // Applies one accepted item and queues the view it should produce.
        function void note_item(logic [ACT_BITS-1:0] act, logic [KEY_BITS-1:0] key,
                                logic [TAG_BITS-1:0] tag);
            t_heap_view           want;
            logic [STAT_BITS-1:0] status;
            logic [KEY_BITS-1:0]  half;
            int unsigned          low;
            bit                   had;
            had    = held[key];
            half   = key >> 1;
            status = ST_OK;
            case (act)
                ACT_INSERT: begin
                    if (entries >= room()) begin
                        status = ST_FULL;
                    end else if (had) begin
                        status = ST_KEY_PRESENT;
                    end else begin
                        held[key]   = 1'b1;
                        tag_of[key] = tag;
                        entries++;
                    end
                end
                ACT_HALVE: begin
                    // Halving zero lands on zero itself, which is held.
                    if (!had) begin
                        status = ST_KEY_ABSENT;
                    end else if (held[half]) begin
                        status = ST_HALF_PRESENT;
                    end else begin
                        held[key]    = 1'b0;
                        held[half]   = 1'b1;
                        tag_of[half] = tag_of[key];
                    end
                end
                ACT_REMOVE: begin
                    if (entries == 0) begin
                        status = ST_EMPTY;
                    end else begin
                        held[smallest_key()] = 1'b0;
                        entries--;
                    end
                end
                default: begin
                end
            endcase
            low              = smallest_key();
            want.status      = status;
            want.was_present = had;
            want.min_key     = (entries != 0) ? low[KEY_BITS-1:0] : '0;
            want.min_tag     = (entries != 0) ? tag_of[low] : '0;
            want.count       = CNT_BITS'(entries);
            want.empty       = (entries == 0);
            want.full        = (entries >= room());
            view_q.push_back(want);
        endfunction

        task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
            $display("mismatch in %s: got 0x%0h, expected 0x%0h", field, got, want);
            mismatches++;
        endtask

        // Compares one result from the block with the oldest expected view.
        task check_result(t_heap_view got);
            t_heap_view want;
            if (view_q.size() == 0) begin
                report_mismatch("result with nothing expected", 32'(got.status), 32'(0));
                return;
            end
            want = view_q.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.was_present !== want.was_present)
                report_mismatch("key_was_present", 32'(got.was_present),
                                32'(want.was_present));
            if (got.min_key !== want.min_key)
                report_mismatch("min_key", 32'(got.min_key), 32'(want.min_key));
            if (got.min_tag !== want.min_tag)
                report_mismatch("min_payload", 32'(got.min_tag), 32'(want.min_tag));
            if (got.count !== want.count)
                report_mismatch("entry_count", 32'(got.count), 32'(want.count));
            if (got.empty !== want.empty)
                report_mismatch("is_empty", 32'(got.empty), 32'(want.empty));
            if (got.full !== want.full)
                report_mismatch("is_full", 32'(got.full), 32'(want.full));
        endtask
    endclass

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  i_valid   = 1'b0;
    logic [ACT_BITS-1:0]   i_action  = ACT_INSERT;
    logic [KEY_BITS-1:0]   i_key     = '0;
    logic [TAG_BITS-1:0]   i_payload = '0;
    logic                  i_cfg_we  = 1'b0;
    logic [CFG_BITS-1:0]   i_cfg_data = '0;
    logic                  i_stall   = 1'b0;
    logic                  o_stall;
    logic                  o_valid;
    logic [STAT_BITS-1:0]  o_status;
    logic                  o_key_was_present;
    logic [KEY_BITS-1:0]   o_min_key;
    logic [TAG_BITS-1:0]   o_min_payload;
    logic [CNT_BITS-1:0]   o_entry_count;
    logic                  o_is_empty;
    logic                  o_is_full;

    t_heap_scoreboard book = new();
    bit             steady_flow  = 1'b0;
    bit             hold_request = 1'b0;
    bit             hold_done    = 1'b0;
    int unsigned    stalled_cycles = 0;

    indexed_min_heap_halve_key #(
        .CAPACITY(HEAP_SLOTS)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_action          (i_action),
        .i_key             (i_key),
        .i_payload         (i_payload),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .o_key_was_present (o_key_was_present),
        .o_min_key         (o_min_key),
        .o_min_payload     (o_min_payload),
        .o_entry_count     (o_entry_count),
        .o_is_empty        (o_is_empty),
        .o_is_full         (o_is_full)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offers one item after a random gap and waits until the block takes it.
    task automatic offer_item(input logic [ACT_BITS-1:0] act, input logic [KEY_BITS-1:0] key,
                              input logic [TAG_BITS-1:0] tag);
        int unsigned gap;
        gap = gap_len();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_action  <= act;
        i_key     <= key;
        i_payload <= tag;
        do @(posedge i_clk); while (o_stall);
        book.note_item(act, key, tag);
    endtask

    // Stops offering and waits until every expected result has come back.
    task automatic drain();
        i_valid <= 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CFG_BITS-1:0] value);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        book.set_capacity(value);
    endtask

    // Random item; halves mostly aim at a key that is held.
    task automatic random_item(input int unsigned key_range);
        int unsigned         r;
        logic [ACT_BITS-1:0] act;
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
        r   = $urandom_range(0, 99);
        act = (r < 45) ? ACT_INSERT : (r < 70) ? ACT_HALVE : (r < 95) ? ACT_REMOVE : ACT_SPARE;
        key = KEY_BITS'($urandom_range(0, key_range - 1));
        if (act == ACT_HALVE && $urandom_range(0, 3) != 0) key = book.pick_held_key(key);
        tag = TAG_BITS'($urandom);
        offer_item(act, key, tag);
    endtask

    // Result side: random stalls, occasional long ones, and one long hold-off
    // on request so that the block backs up into its input.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_done) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
                i_stall <= 1'b0;
            end else if (steady_flow) begin
                i_stall <= 1'b0;
            end else if ($urandom_range(0, 149) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(20, 60)) @(posedge i_clk);
            end else begin
                i_stall <= ($urandom_range(0, 99) < 25);
            end
        end
    end

    // Check every result the block hands over.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            book.check_result('{o_status, o_key_was_present, o_min_key, o_min_payload,
                                o_entry_count, o_is_empty, o_is_full});
        end
    end

    // End the run when neither channel has moved for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stalled_cycles <= 0;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
        if (stalled_cycles >= IDLE_LIMIT) begin
            $display("indexed_min_heap_halve_key_test: errors");
            $finish;
        end
    end

    initial begin
        logic [CFG_BITS-1:0] phase_caps[8];
        phase_caps = '{7'd127, 7'd40, 7'd5, 7'd0, 7'd1, 7'd1, 7'd64, 7'd64};
        phase_caps[4] = CFG_BITS'($urandom_range(1, 127));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Refusals on an empty heap, key and payload extremes, duplicate keys.
        offer_item(ACT_REMOVE, 8'd0, 16'h0000);
        offer_item(ACT_HALVE, 8'd9, 16'h0000);
        offer_item(ACT_INSERT, 8'd255, 16'h0000);
        offer_item(ACT_INSERT, 8'd0, 16'hFFFF);
        offer_item(ACT_INSERT, 8'd0, 16'h1234);
        // Halving zero gives zero, which is already held.
        offer_item(ACT_HALVE, 8'd0, 16'h0000);
        offer_item(ACT_INSERT, 8'd200, 16'hA5A5);
        offer_item(ACT_HALVE, 8'd200, 16'hFFFF);
        offer_item(ACT_INSERT, 8'd50, 16'h5A5A);
        // The halved key would collide with one already held.
        offer_item(ACT_HALVE, 8'd100, 16'h0000);
        offer_item(ACT_SPARE, 8'd50, 16'hFFFF);
        offer_item(ACT_REMOVE, 8'hFF, 16'hFFFF);
        offer_item(ACT_HALVE, 8'd255, 16'h0000);
        repeat (3) offer_item(ACT_REMOVE, 8'd0, 16'h0000);
        offer_item(ACT_REMOVE, 8'd0, 16'h0000);

        // A heap of one entry, then a heap that can hold nothing.
        write_capacity(7'd1);
        offer_item(ACT_INSERT, 8'd7, 16'h00FF);
        offer_item(ACT_INSERT, 8'd8, 16'hFF00);
        offer_item(ACT_HALVE, 8'd7, 16'h0000);
        offer_item(ACT_REMOVE, 8'd0, 16'h0000);
        write_capacity(7'd0);
        offer_item(ACT_INSERT, 8'd1, 16'h0001);
        offer_item(ACT_REMOVE, 8'd0, 16'h0000);

        // Random phases; entries left over from one phase meet the next capacity.
        for (int p = 0; p < 8; p++) begin
            write_capacity(phase_caps[p]);
            steady_flow  = (p == 6);
            hold_request = (p == 1);
            repeat (PHASE_ITEMS) random_item((p % 2 == 1) ? 32 : KEY_SPAN);
        end
        steady_flow = 1'b0;

        drain();
        if (book.mismatches == 0) begin
            $display("indexed_min_heap_halve_key_test: clean");
        end else begin
            $display("indexed_min_heap_halve_key_test: errors");
        end
        $finish;
    end

endmodule
